### hw/rtl/connection_slot_evictor_macros.svh
// assertion helpers for the slot evictor
`ifndef CONNECTION_SLOT_EVICTOR_MACROS_SVH
`define CONNECTION_SLOT_EVICTOR_MACROS_SVH

// same-cycle implication
`define CSE_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define CSE_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### hw/rtl/cse_pkg.sv
// ----------------------------------------------------------------------------
// cse_pkg
// shared types and codes of the connection slot evictor
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package cse_pkg;

  localparam logic [1:0] REQ_UPDATE  = 2'd0;
  localparam logic [1:0] REQ_RELEASE = 2'd1;
  localparam logic [1:0] REQ_ALLOC   = 2'd2;

  localparam logic [1:0] CONN_SEND_BODY = 2'd3;

  typedef struct packed {
    logic [63:0] addr_high;
    logic [63:0] addr_low;
    logic        family;
    logic [1:0]  conn_state;
    logic [2:0]  resp_type;
    logic [31:0] progress;
  } rec_t;

  typedef struct packed {
    logic shift;
    logic wr_all;
    logic wr_fields;
  } cell_ctl_t;

endpackage

`default_nettype wire

### hw/rtl/cse_cell.sv
// ----------------------------------------------------------------------------
// cse_cell
// one slot record; rotates to its neighbor during a victim scan
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cse_cell
  import cse_pkg::*;
(
  input  wire        clk,
  input  cell_ctl_t  ctl,
  input  rec_t       shift_in,
  input  rec_t       wdata,
  output rec_t       rec
);

  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      rec <= shift_in;
    end else if (ctl.wr_all) begin
      rec <= wdata;
    end else if (ctl.wr_fields) begin
      rec.conn_state <= wdata.conn_state;
      rec.resp_type  <= wdata.resp_type;
      rec.progress   <= wdata.progress;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/cse_judge.sv
// ----------------------------------------------------------------------------
// cse_judge
// address match and candidate takeover for one scan step
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cse_judge
  import cse_pkg::*;
(
  input  rec_t ir,
  input  rec_t cand,
  input  rec_t head,
  output logic eq,
  output logic take
);

  always_comb begin
    if (ir.family != head.family) begin
      eq = 1'b0;
    end else if (ir.family) begin
      eq = (ir.addr_high == head.addr_high) && (ir.addr_low == head.addr_low);
    end else begin
      eq = (ir.addr_low[31:0] == head.addr_low[31:0]);
    end
  end

  always_comb begin
    if (head.conn_state < cand.conn_state) begin
      take = eq;
    end else if (head.conn_state == cand.conn_state) begin
      // send-body tie uses the outer slot's type
      if (cand.conn_state == CONN_SEND_BODY && ir.resp_type != cand.resp_type) begin
        take = eq && (ir.resp_type < cand.resp_type);
      end else begin
        take = eq && (head.progress < cand.progress);
      end
    end else begin
      take = 1'b0;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/connection_slot_evictor.sv
// ----------------------------------------------------------------------------
// connection_slot_evictor
// connection slot table with free-slot allocation and victim eviction
// ----------------------------------------------------------------------------
// Update, release, unknown requests and allocates that find a free slot are
// answered as the word is accepted: its result is registered at that edge.
// An allocate into a full table scans all pairs of slots: the records rotate
// around a ring of SLOTS cells, one position per cycle, and a single judge
// compares the head of the ring against the outer slot; a write state that
// waits for a free output follows. No new word is accepted during either.
`timescale 1ns / 1ps
`default_nettype none

module connection_slot_evictor
  import cse_pkg::*;
#(
  parameter int SLOTS = 16
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         in_valid,
  output logic        in_ready,
  input  wire  [1:0]  req_type,
  input  wire  [3:0]  slot,
  input  wire  [63:0] addr_high,
  input  wire  [63:0] addr_low,
  input  wire         addr_is_v6,
  input  wire  [1:0]  conn_state,
  input  wire  [2:0]  resp_type,
  input  wire  [31:0] progress,
  output logic        out_valid,
  input  wire         out_ready,
  output logic [3:0]  slot_index,
  output logic        dropped
);

`include "connection_slot_evictor_macros.svh"

  localparam int IW = $clog2(SLOTS);
  localparam int CW = $clog2(SLOTS + 1);
  localparam int SW = IW + 4;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_WRITE = 2'd2;

  logic [1:0]       st;
  logic [SLOTS-1:0] slot_valid;

  // ring of slot records
  rec_t      recs [SLOTS];
  rec_t      wdata;
  logic [IW-1:0] wsel;
  logic      wr_all, wr_fields, shift;

  for (genvar k = 0; k < SLOTS; k++) begin : g_cell
    cell_ctl_t ctl;
    always_comb begin
      ctl.shift     = shift;
      ctl.wr_all    = wr_all && (wsel == IW'(k));
      ctl.wr_fields = wr_fields && (wsel == IW'(k));
    end
    cse_cell u_cell (
      .clk      (clk),
      .ctl      (ctl),
      .shift_in (recs[(k + 1) % SLOTS]),
      .wdata    (wdata),
      .rec      (recs[k])
    );
  end

  // scan registers
  rec_t          ir, nx, cand, pend;
  logic [IW-1:0] i_cnt, j_cnt, cand_idx, best;
  logic [CW-1:0] cnt, best_cnt;
  logic          eq, take;

  cse_judge u_judge (
    .ir   (ir),
    .cand (cand),
    .head (recs[0]),
    .eq   (eq),
    .take (take)
  );

  // first free slot
  logic          any_free;
  logic [IW-1:0] free_idx;
  always_comb begin
    free_idx = '0;
    for (int k = SLOTS - 1; k >= 0; k--) begin
      if (!slot_valid[k]) free_idx = IW'(k);
    end
    any_free = ~&slot_valid;
  end

  logic [SW-1:0] slot_ext;
  logic          in_range;
  assign slot_ext = SW'(slot);
  assign in_range = slot_ext < SW'(SLOTS);

  logic out_free, accept, wr_go, pass_end, scan_end;
  assign out_free = !out_valid || out_ready;
  assign in_ready = (st == ST_IDLE) && out_free;
  assign accept   = in_valid && in_ready;
  assign wr_go    = (st == ST_WRITE) && out_free;
  assign pass_end = (st == ST_SCAN) && (j_cnt == IW'(SLOTS - 1));
  assign scan_end = pass_end && (i_cnt == IW'(SLOTS - 1));
  assign shift    = (st == ST_SCAN);

  logic [IW-1:0] cand_fin;
  logic [CW-1:0] cnt_fin;
  assign cand_fin = take ? j_cnt : cand_idx;
  assign cnt_fin  = cnt + CW'(eq);

  logic [IW+3:0] best_w, free_w;
  assign best_w = {4'b0, best};
  assign free_w = {4'b0, free_idx};

  // write port of the ring
  always_comb begin
    wr_all    = 1'b0;
    wr_fields = 1'b0;
    wsel      = slot_ext[IW-1:0];
    wdata.addr_high  = addr_high;
    wdata.addr_low   = addr_low;
    wdata.family     = addr_is_v6;
    wdata.conn_state = (req_type == REQ_UPDATE) ? conn_state : 2'd0;
    wdata.resp_type  = (req_type == REQ_UPDATE) ? resp_type : 3'd0;
    wdata.progress   = (req_type == REQ_UPDATE) ? progress : 32'd0;
    if (st == ST_WRITE) begin
      wdata  = pend;
      wsel   = best;
      wr_all = wr_go;
    end else if (accept) begin
      if (req_type == REQ_UPDATE) begin
        wr_fields = in_range;
      end else if (req_type == REQ_ALLOC && any_free) begin
        wsel   = free_idx;
        wr_all = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st         <= ST_IDLE;
      slot_valid <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      unique case (st)
        ST_IDLE: begin
          if (accept) begin
            priority if (req_type == REQ_ALLOC && !any_free) begin
              st <= ST_SCAN;
            end else begin
              out_valid <= 1'b1;
            end
            if (req_type == REQ_RELEASE && in_range) slot_valid[slot_ext[IW-1:0]] <= 1'b0;
            if (req_type == REQ_ALLOC && any_free) slot_valid[free_idx] <= 1'b1;
          end
        end
        ST_SCAN: begin
          if (scan_end) st <= ST_WRITE;
        end
        ST_WRITE: begin
          if (wr_go) begin
            st        <= ST_IDLE;
            out_valid <= 1'b1;
          end
        end
        default: st <= ST_IDLE;
      endcase
    end
  end

  // result and scan payload
  always_ff @(posedge clk) begin
    if (accept) begin
      slot_index <= slot;
      dropped    <= 1'b0;
      if (req_type == REQ_ALLOC && any_free) slot_index <= free_w[3:0];
      // scan setup, outer slot zero sits at the ring head
      pend     <= wdata;
      ir       <= recs[0];
      cand     <= recs[0];
      cand_idx <= '0;
      i_cnt    <= '0;
      j_cnt    <= '0;
      cnt      <= '0;
      best     <= '0;
      best_cnt <= '0;
    end
    if (st == ST_SCAN) begin
      j_cnt <= pass_end ? '0 : j_cnt + IW'(1);
      cnt   <= cnt_fin;
      if (take) begin
        cand     <= recs[0];
        cand_idx <= j_cnt;
      end
      // next outer slot passes the head during this pass
      if (i_cnt != IW'(SLOTS - 1) && j_cnt == i_cnt + IW'(1)) nx <= recs[0];
      if (pass_end) begin
        if (cnt_fin > best_cnt) begin
          best     <= cand_fin;
          best_cnt <= cnt_fin;
        end
        ir       <= nx;
        cand     <= nx;
        cand_idx <= i_cnt + IW'(1);
        i_cnt    <= i_cnt + IW'(1);
        cnt      <= '0;
      end
    end
    if (wr_go) begin
      slot_index <= best_w[3:0];
      dropped    <= 1'b1;
    end
  end

  // a scan runs only on a full table
  `CSE_ASSERT_NOW(a_scan_full, st != ST_IDLE, &slot_valid)
  // no word is taken while a scan is in flight
  `CSE_ASSERT_NOW(a_busy_ready, st != ST_IDLE, !in_ready)
  // an eviction reports dropped
  `CSE_ASSERT_NEXT(a_evict_drop, wr_go, out_valid && dropped)
  // a finished scan leaves a nonempty group
  `CSE_ASSERT_NOW(a_best_cnt, st == ST_WRITE, best_cnt != '0)

endmodule

`default_nettype wire

### test/tb_connection_slot_evictor.sv
// ----------------------------------------------------------------------------
// tb_connection_slot_evictor
// self-checking bench: table predictor, full-table eviction and random traffic
// ----------------------------------------------------------------------------
// every accepted request word is run through a local model of the slot table,
// and its expected slot index and dropped flag wait in order for the dut's
// result words. addresses come from a small pool so that groups form and the
// victim search sees ties, send-body type tie-breaks and progress ordering.
`timescale 1ns / 1ps
`default_nettype none

module tb_connection_slot_evictor;
  import cse_pkg::*;

  localparam int NSLOT = 16;
  localparam int POOL  = 6;

  // request code the block does not know
  localparam logic [1:0] REQ_UNKNOWN = 2'd3;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  req_type = REQ_UPDATE;
  logic [3:0]  slot = '0;
  logic [63:0] addr_high = '0;
  logic [63:0] addr_low = '0;
  logic        addr_is_v6 = 1'b0;
  logic [1:0]  conn_state = '0;
  logic [2:0]  resp_type = '0;
  logic [31:0] progress = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [3:0]  slot_index;
  logic        dropped;

  connection_slot_evictor #(.SLOTS(NSLOT)) dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .req_type(req_type), .slot(slot),
    .addr_high(addr_high), .addr_low(addr_low), .addr_is_v6(addr_is_v6),
    .conn_state(conn_state), .resp_type(resp_type), .progress(progress),
    .out_valid(out_valid), .out_ready(out_ready),
    .slot_index(slot_index), .dropped(dropped)
  );

  always #5 clk = ~clk;

  // one expected result word
  typedef struct {
    logic [3:0] idx;
    logic       drop;
  } grant_t;

  // local copy of the slot table
  logic        tbl_valid [NSLOT];
  logic [63:0] tbl_hi    [NSLOT];
  logic [63:0] tbl_lo    [NSLOT];
  logic        tbl_v6    [NSLOT];
  logic [1:0]  tbl_state [NSLOT];
  logic [2:0]  tbl_type  [NSLOT];
  logic [31:0] tbl_prog  [NSLOT];

  grant_t      grants_due[$];

  // address pool shared by the directed and random parts
  logic [63:0] pool_hi [POOL];
  logic [63:0] pool_lo [POOL];
  logic        pool_v6 [POOL];

  bit idle_on = 1'b1;
  int errors = 0;
  int words_sent = 0;
  int evictions = 0;
  int results_seen = 0;

  // ---------------------------------------------------------------- predictor
  function automatic bit same_client(int a, int b);
    if (tbl_v6[a] != tbl_v6[b]) return 1'b0;
    if (tbl_v6[a]) return tbl_hi[a] == tbl_hi[b] && tbl_lo[a] == tbl_lo[b];
    return tbl_lo[a][31:0] == tbl_lo[b][31:0];
  endfunction

  // victim comes from the largest address group, first group wins ties
  function automatic int choose_victim();
    int best_slot;
    int best_cnt;
    int cand;
    int cnt;
    best_slot = 0;
    best_cnt = 0;
    for (int i = 0; i < NSLOT; i++) begin
      cand = i;
      cnt = 0;
      for (int j = 0; j < NSLOT; j++) begin
        if (!same_client(i, j)) continue;
        cnt++;
        if (tbl_state[j] < tbl_state[cand]) begin
          cand = j;
        end else if (tbl_state[j] == tbl_state[cand]) begin
          // send-body tie-break looks at the outer slot's type
          if (tbl_state[cand] == CONN_SEND_BODY && tbl_type[i] != tbl_type[cand]) begin
            if (tbl_type[i] < tbl_type[cand]) cand = j;
          end else if (tbl_prog[j] < tbl_prog[cand]) begin
            cand = j;
          end
        end
      end
      if (cnt > best_cnt) begin
        best_slot = cand;
        best_cnt = cnt;
      end
    end
    return best_slot;
  endfunction

  function automatic grant_t apply_request(logic [1:0] rq, logic [3:0] sl, logic [63:0] hi,
                                           logic [63:0] lo, logic v6, logic [1:0] st,
                                           logic [2:0] rt, logic [31:0] pg);
    grant_t g;
    int k;
    bit found;
    g.idx = sl;
    g.drop = 1'b0;
    found = 1'b0;
    case (rq)
      REQ_UPDATE: begin
        tbl_state[sl] = st;
        tbl_type[sl] = rt;
        tbl_prog[sl] = pg;
      end
      REQ_RELEASE: begin
        tbl_valid[sl] = 1'b0;
      end
      REQ_ALLOC: begin
        k = 0;
        for (int n = 0; n < NSLOT; n++) begin
          if (!found && !tbl_valid[n]) begin
            k = n;
            found = 1'b1;
          end
        end
        if (!found) begin
          k = choose_victim();
          g.drop = 1'b1;
        end
        tbl_valid[k] = 1'b1;
        tbl_hi[k] = hi;
        tbl_lo[k] = lo;
        tbl_v6[k] = v6;
        tbl_state[k] = '0;
        tbl_type[k] = '0;
        tbl_prog[k] = '0;
        g.idx = 4'(k);
      end
      default: ;
    endcase
    return g;
  endfunction

  // ----------------------------------------------------------------- sender
  // sends one word, optionally after a random idle burst, and books its result
  task automatic send_word(logic [1:0] rq, logic [3:0] sl, logic [63:0] hi, logic [63:0] lo,
                           logic v6, logic [1:0] st, logic [2:0] rt, logic [31:0] pg);
    grant_t g;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_valid   <= 1'b1;
    req_type   <= rq;
    slot       <= sl;
    addr_high  <= hi;
    addr_low   <= lo;
    addr_is_v6 <= v6;
    conn_state <= st;
    resp_type  <= rt;
    progress   <= pg;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    g = apply_request(rq, sl, hi, lo, v6, st, rt, pg);
    if (g.drop) evictions++;
    grants_due.push_back(g);
    words_sent++;
  endtask

  task automatic alloc_pool(int p);
    send_word(REQ_ALLOC, 4'($urandom), pool_hi[p], pool_lo[p], pool_v6[p], 2'($urandom),
              3'($urandom), $urandom);
  endtask

  task automatic update_slot(int s, logic [1:0] st, logic [2:0] rt, logic [31:0] pg);
    send_word(REQ_UPDATE, 4'(s), {$urandom, $urandom}, {$urandom, $urandom}, 1'($urandom),
              st, rt, pg);
  endtask

  // lowers valid and holds off until every booked result has come back
  task automatic wait_quiet();
    in_valid <= 1'b0;
    @(posedge clk);
    while (grants_due.size() != 0) @(posedge clk);
  endtask

  // ------------------------------------------------------------ receiver side
  int stall_left = 0;
  always @(posedge clk) begin
    if (!idle_on) begin
      out_ready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready <= (stall_left == 1);
    end else if ($urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(1, 9);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // result check against the oldest booked word
  always @(posedge clk) begin
    grant_t g;
    if (!rst && out_valid && out_ready) begin
      results_seen++;
      if (grants_due.size() == 0) begin
        $display("%0t: result word with nothing pending: slot_index %0d dropped %0d",
                 $time, slot_index, dropped);
        errors++;
      end else begin
        g = grants_due.pop_front();
        if (slot_index !== g.idx) begin
          $display("%0t: slot_index expected %0d actual %0d", $time, g.idx, slot_index);
          errors++;
        end
        if (dropped !== g.drop) begin
          $display("%0t: dropped expected %0d actual %0d", $time, g.drop, dropped);
          errors++;
        end
      end
    end
  end

  // ------------------------------------------------------------------ tests
  task automatic do_reset();
    for (int n = 0; n < NSLOT; n++) tbl_valid[n] = 1'b0;
    rst <= 1'b1;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
  endtask

  // fill the table, shape groups and ties, then force evictions
  task automatic test_directed_evict();
    for (int n = 0; n < NSLOT; n++) alloc_pool(n < 7 ? 0 : (n < 12 ? 1 : (n % POOL)));
    update_slot(2, CONN_SEND_BODY, 3'd7, 32'hFFFF_FFFF);
    update_slot(4, CONN_SEND_BODY, 3'd0, 32'h0);
    update_slot(0, CONN_SEND_BODY, 3'd5, 32'h10);
    send_word(REQ_ALLOC, 4'hF, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1,
              2'd3, 3'd7, 32'hFFFF_FFFF);
    send_word(REQ_ALLOC, 4'h0, 64'h0, 64'h0, 1'b0, 2'd0, 3'd0, 32'h0);
    alloc_pool(1);
  endtask

  // release, update of a free slot, release of a free slot, unknown request
  task automatic test_release_paths();
    send_word(REQ_RELEASE, 4'd9, '0, '0, 1'b0, '0, '0, '0);
    update_slot(9, 2'd2, 3'd3, 32'h1234);
    send_word(REQ_RELEASE, 4'd9, '0, '0, 1'b0, '0, '0, '0);
    send_word(REQ_UNKNOWN, 4'hF, {$urandom, $urandom}, {$urandom, $urandom}, 1'b1, 2'd3,
              3'd7, 32'hFFFF_FFFF);
    alloc_pool(2);
  endtask

  // random traffic drawn mostly from the pool so groups and ties keep forming
  task automatic test_random(int count);
    int pick;
    logic [1:0] st;
    logic [2:0] rt;
    logic [31:0] pg;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      st = 2'($urandom);
      rt = ($urandom_range(0, 1) != 0) ? 3'($urandom_range(0, 2)) : 3'($urandom);
      pg = ($urandom_range(0, 2) != 0) ? 32'($urandom_range(0, 3)) : 32'($urandom);
      if (pick < 40) begin
        if ($urandom_range(0, 4) == 0)
          send_word(REQ_ALLOC, 4'($urandom), {$urandom, $urandom}, {$urandom, $urandom},
                    1'($urandom), 2'($urandom), 3'($urandom), $urandom);
        else
          alloc_pool($urandom_range(0, POOL - 1));
      end else if (pick < 80) begin
        update_slot($urandom_range(0, NSLOT - 1), st, rt, pg);
      end else if (pick < 92) begin
        send_word(REQ_RELEASE, 4'($urandom), {$urandom, $urandom}, {$urandom, $urandom},
                  1'($urandom), st, rt, pg);
      end else begin
        send_word(REQ_UNKNOWN, 4'($urandom), {$urandom, $urandom}, {$urandom, $urandom},
                  1'($urandom), st, rt, pg);
      end
    end
  endtask

  initial begin
    // pool: two ipv4 entries share low 32 bits but differ above, so they group
    for (int p = 0; p < POOL; p++) begin
      pool_hi[p] = {$urandom, $urandom};
      pool_lo[p] = {$urandom, $urandom};
      pool_v6[p] = (p >= 3);
    end
    pool_lo[2] = {~pool_lo[0][63:32], pool_lo[0][31:0]};
    pool_hi[5] = pool_hi[3];

    do_reset();
    test_directed_evict();
    test_release_paths();
    wait_quiet();
    test_random(1500);
    wait_quiet();
    idle_on = 1'b0;
    test_random(280);
    wait_quiet();
    repeat (300) @(posedge clk);

    $display("covered %0d request words, %0d results, %0d full-table evictions",
             words_sent, results_seen, evictions);
    $display("with random idle on both sides, then a back-to-back tail");
    if (errors == 0 && grants_due.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

`default_nettype wire
